@@ rtl/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/shrn_pkg.sv @@
package shrn_pkg;

    localparam int ROUNDS = 16;
    localparam int ROUND_CNT = (ROUNDS > 16) ? 16 : ROUNDS;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE_BASE = 2'd1;

    localparam logic [31:0] TARGET_RESET     = 32'd15;
    localparam logic [31:0] NONCE_BASE_RESET = 32'd0;

    localparam logic [31:0] ROUND_K [16] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174
    };

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef struct packed {
        logic [31:0] nonce;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
        logic [31:0] f;
        logic [31:0] g;
        logic [31:0] h;
    } work_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic work_t sha_round(input work_t s, input logic [31:0] k,
                                        input logic [31:0] w);
        logic [31:0] s1;
        logic [31:0] ch;
        logic [31:0] t1;
        logic [31:0] s0;
        logic [31:0] mj;
        logic [31:0] t2;
        work_t r;
        s1 = rotr(s.e, 6) ^ rotr(s.e, 11) ^ rotr(s.e, 25);
        ch = (s.e & s.f) ^ (~s.e & s.g);
        t1 = s.h + s1 + ch + k + w;
        s0 = rotr(s.a, 2) ^ rotr(s.a, 13) ^ rotr(s.a, 22);
        mj = (s.a & s.b) ^ (s.a & s.c) ^ (s.b & s.c);
        t2 = s0 + mj;
        r.nonce = s.nonce;
        r.h = s.g;
        r.g = s.f;
        r.f = s.e;
        r.e = s.d + t1;
        r.d = s.c;
        r.c = s.b;
        r.b = s.a;
        r.a = t1 + t2;
        sha_round = r;
    endfunction

endpackage

@@ rtl/shrn_nonce_stage.sv @@
`include "assert_macros.svh"

module shrn_nonce_stage
    import shrn_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] work_index,
    input  logic [31:0] nonce_base,
    output logic        out_valid,
    input  logic        out_ready,
    output work_t       out_data
);

    logic        valid_reg;
    logic [31:0] nonce_reg;
    logic [31:0] nonce_next;

    assign in_ready   = !valid_reg || out_ready;
    assign nonce_next = work_index + nonce_base;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            nonce_reg <= nonce_next;
        end
    end

    // working variables start from the initial hash values
    always_comb begin
        out_data.nonce = nonce_reg;
        out_data.a = INIT_H[0];
        out_data.b = INIT_H[1];
        out_data.c = INIT_H[2];
        out_data.d = INIT_H[3];
        out_data.e = INIT_H[4];
        out_data.f = INIT_H[5];
        out_data.g = INIT_H[6];
        out_data.h = INIT_H[7];
    end

    assign out_valid = valid_reg;

    `ASSERT_NEXT(a_nonce_sum, aclk, aresetn, in_valid && in_ready,
                 nonce_reg == $past(work_index) + $past(nonce_base))

endmodule

@@ rtl/shrn_round_stage.sv @@
`include "assert_macros.svh"

module shrn_round_stage
    import shrn_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  work_t       in_data,
    input  logic [31:0] k_word,
    input  logic [31:0] w_word,
    output logic        out_valid,
    input  logic        out_ready,
    output work_t       out_data
);

    logic  valid_reg;
    work_t data_reg;
    work_t data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign data_next = sha_round(in_data, k_word, w_word);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // a stalled stage keeps its item
    `ASSERT_NEXT(a_stage_hold, aclk, aresetn, valid_reg && !out_ready,
                 valid_reg && $stable(data_reg))

endmodule

@@ rtl/shrn_hit_stage.sv @@
module shrn_hit_stage
    import shrn_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  work_t       in_data,
    input  logic [31:0] target,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_nonce_out,
    output logic [31:0] m_word_a,
    output logic        m_hit
);

    logic        valid_reg;
    logic [31:0] nonce_reg;
    logic [31:0] word_a_reg;
    logic        hit_reg;
    logic        hit_next;

    assign in_ready = !valid_reg || m_ready;
    assign hit_next = in_data.a < target;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            nonce_reg  <= in_data.nonce;
            word_a_reg <= in_data.a;
            hit_reg    <= hit_next;
        end
    end

    assign m_valid     = valid_reg;
    assign m_nonce_out = nonce_reg;
    assign m_word_a    = word_a_reg;
    assign m_hit       = hit_reg;

endmodule

@@ rtl/sha256_reduced_round_nonce_test.sv @@
// channel  | direction | handshake           | payload
// input    | in        | s_valid / s_ready   | s_work_index[31:0]
// result   | out       | m_valid / m_ready   | m_nonce_out[31:0], m_word_a[31:0], m_hit
// config   | in        | cfg_wr_en           | cfg_index[1:0], cfg_data[31:0]
//
// one item per cycle sustained while m_ready is high; the pipeline registers an item in
// a nonce add stage, one register stage per compression round, and a compare stage
// each stage holds one item and moves on when the next stage has room, so a stall
// on m_ready backs up stage by stage and s_ready drops once every stage is full
// aresetn is synchronous, active low; it empties the pipeline and loads register resets
`include "assert_macros.svh"

module sha256_reduced_round_nonce_test
    import shrn_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [31:0]          s_work_index,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [31:0]          m_nonce_out,
    output logic [31:0]          m_word_a,
    output logic                 m_hit
);

    logic [31:0] target_reg;
    logic [31:0] nonce_base_reg;

    work_t       stage_data  [ROUND_CNT+1];
    logic        stage_valid [ROUND_CNT+1];
    logic        stage_ready [ROUND_CNT+1];
    logic [31:0] w_word      [ROUND_CNT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg     <= TARGET_RESET;
            nonce_base_reg <= NONCE_BASE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_TARGET:     target_reg     <= cfg_data;
                REG_NONCE_BASE: nonce_base_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    shrn_nonce_stage u_nonce (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .work_index (s_work_index),
        .nonce_base (nonce_base_reg),
        .out_valid  (stage_valid[0]),
        .out_ready  (stage_ready[0]),
        .out_data   (stage_data[0])
    );

    for (genvar i = 0; i < ROUND_CNT; i++) begin : g_round
        // only the first round sees the nonce, the other message words are zero
        if (i == 0) begin : g_first
            assign w_word[i] = stage_data[i].nonce;
        end else begin : g_rest
            assign w_word[i] = '0;
        end

        shrn_round_stage u_round (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stage_valid[i]),
            .in_ready  (stage_ready[i]),
            .in_data   (stage_data[i]),
            .k_word    (ROUND_K[i]),
            .w_word    (w_word[i]),
            .out_valid (stage_valid[i+1]),
            .out_ready (stage_ready[i+1]),
            .out_data  (stage_data[i+1])
        );
    end

    shrn_hit_stage u_hit (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (stage_valid[ROUND_CNT]),
        .in_ready    (stage_ready[ROUND_CNT]),
        .in_data     (stage_data[ROUND_CNT]),
        .target      (target_reg),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_nonce_out (m_nonce_out),
        .m_word_a    (m_word_a),
        .m_hit       (m_hit)
    );

    // a ready sink frees every stage, so the input is never held off
    `ASSERT_IMPL(a_ready_chain, aclk, aresetn, m_ready, s_ready)
    // input only stalls when a finished item waits at the output
    `ASSERT_IMPL(a_stall_source, aclk, aresetn, !s_ready, m_valid && !m_ready)

endmodule

@@ bench/sha256_reduced_round_nonce_test_tb.sv @@
`timescale 1ns / 1ps

module sha256_reduced_round_nonce_test_tb;
    import shrn_pkg::*;

    localparam int SHA_ROUNDS      = ROUND_CNT;
    localparam int RANDOM_SEGMENTS = 8;
    localparam int SEGMENT_ITEMS   = 128;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int TAIL_CYCLES     = 40;
    localparam int STALL_LIMIT     = 1000;
    localparam int MAX_GAP         = 12;
    localparam int REPORT_CAP      = 40;

    // indexes that decode to no register
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    localparam logic [31:0] K_TAB [16] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174
    };

    localparam logic [31:0] H0_TAB [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef struct packed {
        logic [31:0] nonce;
        logic [31:0] word_a;
        logic        hit;
    } candidate_t;

    // optional register write, then one work index; pinned fields are typed in
    typedef struct packed {
        bit                   wr;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [31:0]          reg_val;
        logic [31:0]          work_index;
        bit                   pin_nonce;
        logic [31:0]          nonce;
        bit                   pin_hit;
        logic                 hit;
    } probe_row_t;

    localparam int PROBE_ROWS = 21;
    localparam probe_row_t PROBES [PROBE_ROWS] = '{
        '{1'b0, REG_TARGET,     32'h0,        32'h00000000, 1'b1, 32'h00000000, 1'b0, 1'b0},
        '{1'b0, REG_TARGET,     32'h0,        32'hffffffff, 1'b1, 32'hffffffff, 1'b0, 1'b0},
        '{1'b0, REG_TARGET,     32'h0,        32'h00000001, 1'b1, 32'h00000001, 1'b0, 1'b0},
        '{1'b0, REG_TARGET,     32'h0,        32'h80000000, 1'b1, 32'h80000000, 1'b0, 1'b0},
        '{1'b0, REG_TARGET,     32'h0,        32'h7fffffff, 1'b1, 32'h7fffffff, 1'b0, 1'b0},
        '{1'b0, REG_TARGET,     32'h0,        32'h55555555, 1'b1, 32'h55555555, 1'b0, 1'b0},
        '{1'b0, REG_TARGET,     32'h0,        32'haaaaaaaa, 1'b1, 32'haaaaaaaa, 1'b0, 1'b0},
        // target zero never hits
        '{1'b1, REG_TARGET,     32'h0,        32'h00000000, 1'b1, 32'h00000000, 1'b1, 1'b0},
        '{1'b0, REG_TARGET,     32'h0,        32'hffffffff, 1'b1, 32'hffffffff, 1'b1, 1'b0},
        // base wraps the nonce
        '{1'b1, REG_NONCE_BASE, 32'hffffffff, 32'h00000001, 1'b1, 32'h00000000, 1'b1, 1'b0},
        '{1'b0, REG_TARGET,     32'h0,        32'h00000000, 1'b1, 32'hffffffff, 1'b1, 1'b0},
        '{1'b0, REG_TARGET,     32'h0,        32'hffffffff, 1'b1, 32'hfffffffe, 1'b1, 1'b0},
        '{1'b1, REG_TARGET,     32'hffffffff, 32'h12345678, 1'b1, 32'h12345677, 1'b0, 1'b0},
        '{1'b1, REG_NONCE_BASE, 32'h80000000, 32'h80000000, 1'b1, 32'h00000000, 1'b0, 1'b0},
        '{1'b0, REG_TARGET,     32'h0,        32'h7fffffff, 1'b1, 32'hffffffff, 1'b0, 1'b0},
        // writes to unused indexes leave both registers alone
        '{1'b1, REG_SPARE_2,    32'h00000000, 32'h00000000, 1'b1, 32'h80000000, 1'b0, 1'b0},
        '{1'b1, REG_SPARE_3,    32'hffffffff, 32'h00000001, 1'b1, 32'h80000001, 1'b0, 1'b0},
        '{1'b1, REG_TARGET,     32'h00000001, 32'h00000000, 1'b1, 32'h80000000, 1'b0, 1'b0},
        '{1'b1, REG_TARGET,     32'h80000000, 32'hdeadbeef, 1'b1, 32'h5eadbeef, 1'b0, 1'b0},
        '{1'b1, REG_NONCE_BASE, 32'h00000000, 32'h00000000, 1'b1, 32'h00000000, 1'b0, 1'b0},
        '{1'b1, REG_TARGET,     TARGET_RESET, 32'h00000000, 1'b1, 32'h00000000, 1'b0, 1'b0}
    };

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [31:0]          s_work_index = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [31:0]          m_nonce_out;
    logic [31:0]          m_word_a;
    logic                 m_hit;

    candidate_t  pending_candidates [$];
    logic [31:0] model_target = TARGET_RESET;
    logic [31:0] model_base = NONCE_BASE_RESET;

    int err_count = 0;
    int items_sent = 0;
    int results_seen = 0;
    int hits_seen = 0;
    int settings_used = 0;
    int idle_cycles = 0;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_off_token = 0;
    int hold_seen = 0;
    int hold_left = 0;

    sha256_reduced_round_nonce_test uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_work_index (s_work_index),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_nonce_out  (m_nonce_out),
        .m_word_a     (m_word_a),
        .m_hit        (m_hit)
    );

    always #5 aclk = ~aclk;

    // sixteen rounds, nonce as message word 0, all later words zero
    function automatic logic [31:0] compress_word_a(input logic [31:0] nonce);
        logic [31:0] a, b, c, d, e, f, g, h;
        logic [31:0] s1, ch, t1, s0, mj;
        int r;
        a = H0_TAB[0]; b = H0_TAB[1]; c = H0_TAB[2]; d = H0_TAB[3];
        e = H0_TAB[4]; f = H0_TAB[5]; g = H0_TAB[6]; h = H0_TAB[7];
        for (r = 0; r < SHA_ROUNDS; r++) begin
            s1 = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
            ch = (e & f) ^ (~e & g);
            t1 = h + s1 + ch + K_TAB[r] + ((r == 0) ? nonce : 32'h0);
            s0 = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
            mj = (a & b) ^ (a & c) ^ (b & c);
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + s0 + mj;
        end
        return a;
    endfunction

    function automatic candidate_t predict_candidate(input logic [31:0] work_index);
        candidate_t cand;
        cand.nonce  = work_index + model_base;
        cand.word_a = compress_word_a(cand.nonce);
        cand.hit    = (cand.word_a < model_target);
        return cand;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (err_count < REPORT_CAP) begin
            $display("error at %0t: %s got %h want %h", $time, what, got, want);
        end
        err_count++;
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_TARGET:     model_target = val;
            REG_NONCE_BASE: model_base = val;
            default: ;
        endcase
        settings_used++;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        while (pending_candidates.size() != 0) @(posedge aclk);
    endtask

    // leaves valid high at the accepting edge so back-to-back items need no toggle
    task automatic send_candidate(input logic [31:0] work_index, input bit pin_nonce,
                                  input logic [31:0] nonce, input bit pin_hit,
                                  input logic hit);
        candidate_t cand;
        s_valid      <= 1'b1;
        s_work_index <= work_index;
        do @(posedge aclk); while (!s_ready);
        cand = predict_candidate(work_index);
        if (pin_nonce) cand.nonce = nonce;
        if (pin_hit) cand.hit = hit;
        pending_candidates.push_back(cand);
        items_sent++;
    endtask

    task automatic idle_gap();
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    always @(posedge aclk) begin
        if (hold_seen != hold_off_token) begin
            hold_seen <= hold_off_token;
            hold_left <= HOLD_OFF_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge aclk) begin : result_check
        candidate_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (m_hit) hits_seen++;
            if (pending_candidates.size() == 0) begin
                report_mismatch("result with no candidate pending, nonce_out",
                                m_nonce_out, 32'h0);
            end else begin
                want = pending_candidates.pop_front();
                if (m_nonce_out !== want.nonce)
                    report_mismatch("nonce_out", m_nonce_out, want.nonce);
                if (m_word_a !== want.word_a)
                    report_mismatch("word_a", m_word_a, want.word_a);
                if (m_hit !== want.hit)
                    report_mismatch("hit", {31'h0, m_hit}, {31'h0, want.hit});
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : watchdog
        while (idle_cycles < STALL_LIMIT) @(posedge aclk);
        $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        int row;
        int seg;
        int n;
        int kind;
        logic [31:0] idx;
        logic [31:0] pivot;
        logic [31:0] pick;
        pivot = 32'h0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        for (row = 0; row < PROBE_ROWS; row++) begin
            if (PROBES[row].wr) begin
                s_valid <= 1'b0;
                wait_drained();
                write_register(PROBES[row].reg_idx, PROBES[row].reg_val);
            end
            send_candidate(PROBES[row].work_index, PROBES[row].pin_nonce,
                           PROBES[row].nonce, PROBES[row].pin_hit, PROBES[row].hit);
        end

        for (seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
            s_valid <= 1'b0;
            wait_drained();
            kind = (seg + seg / 4) % 4;
            case (kind)
                0: begin
                    write_register(REG_TARGET, $urandom);
                    write_register(REG_NONCE_BASE, $urandom);
                end
                1: begin
                    case ($urandom_range(4))
                        0: pick = 32'h00000000;
                        1: pick = 32'h00000001;
                        2: pick = 32'h7fffffff;
                        3: pick = 32'h80000000;
                        default: pick = 32'hffffffff;
                    endcase
                    write_register(REG_TARGET, pick);
                    case ($urandom_range(3))
                        0: pick = 32'h00000000;
                        1: pick = 32'h00000001;
                        2: pick = 32'h80000000;
                        default: pick = 32'hffffffff;
                    endcase
                    write_register(REG_NONCE_BASE, pick);
                end
                2: begin
                    // target sits right at or just above word_a of one chosen index
                    write_register(REG_NONCE_BASE, $urandom);
                    pivot = $urandom;
                    write_register(REG_TARGET, compress_word_a(pivot + model_base)
                                               + {31'h0, 1'($urandom_range(1))});
                end
                default: begin
                    write_register(REG_TARGET, $urandom);
                end
            endcase
            write_register($urandom_range(1) ? REG_SPARE_3 : REG_SPARE_2, $urandom);

            case (seg % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
                1: begin tx_idle_pct = 50; rx_stall_pct <= 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct <= 50; end
                default: begin tx_idle_pct = 38; rx_stall_pct <= 38; end
            endcase

            for (n = 0; n < SEGMENT_ITEMS; n++) begin
                // long receiver hold-off while items keep coming
                if (seg == 0 && n == 20) hold_off_token <= hold_off_token + 1;
                case ($urandom_range(7))
                    0: idx = $urandom_range(63);
                    1: idx = 32'hffffffff - $urandom_range(63);
                    2: idx = (kind == 2) ? pivot : (32'h0 - model_base);
                    3: idx = (kind == 2) ? pivot : $urandom;
                    default: idx = $urandom;
                endcase
                idle_gap();
                send_candidate(idx, 1'b0, 32'h0, 1'b0, 1'b0);
            end
        end

        s_valid <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("covered %0d work items, %0d results (%0d hits) under %0d register writes",
                 items_sent, results_seen, hits_seen, settings_used);
        $display("register extremes, unused indexes, hit boundaries and backpressure exercised");
        if (err_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ sha256_reduced_round_nonce_test.f @@
+incdir+rtl
rtl/shrn_pkg.sv
rtl/shrn_nonce_stage.sv
rtl/shrn_round_stage.sv
rtl/shrn_hit_stage.sv
rtl/sha256_reduced_round_nonce_test.sv
bench/sha256_reduced_round_nonce_test_tb.sv
